/* rtl/rdqkf_pkg.sv */
// types and constants shared by the request deque with kind filter
package rdqkf_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [OP_W-1:0] OP_PUSH_TAIL  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP        = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP_LOW   = 3'd4;
    localparam logic [OP_W-1:0] OP_DROP_KIND3 = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LOW_A = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LOW_B = 4'd2;
    localparam logic [KIND_W-1:0] KIND_HIGH  = 4'd3;

    typedef struct packed {
        logic [DATA_W-1:0] sector_number;
        logic [DATA_W-1:0] sector_count;
        logic [DATA_W-1:0] buffer_address;
        logic [KIND_W-1:0] request_kind;
        logic [DATA_W-1:0] due_frame;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DROP,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

/* rtl/rdqkf_if.sv */
// request and response channel interfaces
interface rdqkf_req_if;
    logic                          valid;
    logic                          ready;
    logic [rdqkf_pkg::OP_W-1:0]    opcode;
    logic [rdqkf_pkg::DATA_W-1:0]  sector_number;
    logic [rdqkf_pkg::DATA_W-1:0]  sector_count;
    logic [rdqkf_pkg::DATA_W-1:0]  buffer_address;
    logic [rdqkf_pkg::KIND_W-1:0]  request_kind;
    logic [rdqkf_pkg::DATA_W-1:0]  due_frame;

    modport source (
        output valid, opcode, sector_number, sector_count, buffer_address,
               request_kind, due_frame,
        input  ready
    );
    modport sink (
        input  valid, opcode, sector_number, sector_count, buffer_address,
               request_kind, due_frame,
        output ready
    );
endinterface

interface rdqkf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rdqkf_pkg::STATUS_W-1:0]  status;
    logic [rdqkf_pkg::COUNT_W-1:0]   entry_count;
    logic [rdqkf_pkg::DATA_W-1:0]    out_sector_number;
    logic [rdqkf_pkg::DATA_W-1:0]    out_sector_count;
    logic [rdqkf_pkg::DATA_W-1:0]    out_buffer_address;
    logic [rdqkf_pkg::KIND_W-1:0]    out_request_kind;
    logic [rdqkf_pkg::DATA_W-1:0]    out_due_frame;

    modport source (
        output valid, status, entry_count, out_sector_number, out_sector_count,
               out_buffer_address, out_request_kind, out_due_frame,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, out_sector_number, out_sector_count,
               out_buffer_address, out_request_kind, out_due_frame,
        output ready
    );
endinterface

/* rtl/request_deque_with_kind_filter_core.sv */
// request deque with kind filter: entry memory, pointers and operation sequencer
//
//  channel  dir  word
//  req      in   opcode, sector_number, sector_count, buffer_address,
//                request_kind, due_frame
//  rsp      out  status, entry_count, out_* fields of popped or head entry
//
//  push, pop, peek and no-op words step through accept, update, memory read and
//  result; a drop walks the held entries between update and memory read, one entry
//  per cycle through the single read port and single write port of the entry memory.
//  reset empties the queue at once; no clearing pass is needed.
//  the next word is taken as soon as the result sits in the output register;
//  a stalled rsp holds the sequencer in its result state.
module request_deque_with_kind_filter_core #(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rdqkf_req_if.sink   req,
    rdqkf_rsp_if.source rsp
);
    import rdqkf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    entry_t mem [DEPTH];

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [OP_W-1:0]     op_reg, op_next;
    entry_t              item_reg, item_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                popped_reg, popped_next;
    logic [AW-1:0]       pop_addr_reg, pop_addr_next;
    logic                low_pair_reg, low_pair_next;
    logic [AW-1:0]       walk_rd_reg, walk_rd_next;
    logic [AW-1:0]       walk_wr_reg, walk_wr_next;
    logic [CW-1:0]       walk_left_reg, walk_left_next;
    logic [CW-1:0]       keep_reg, keep_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    entry_t              out_entry_reg, out_entry_next;
    entry_t              rd_data_reg;

    logic          accept;
    logic          full;
    logic          empty;
    logic          drop_op;
    logic          drop_hit;
    logic          walk_done;
    logic          out_load;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;

    assign accept    = req.valid && req.ready;
    assign full      = (occ_reg == CW'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign drop_op   = (op_reg == OP_DROP_LOW) || (op_reg == OP_DROP_KIND3);
    assign drop_hit  = low_pair_reg
                     ? ((rd_data_reg.request_kind == KIND_LOW_A) ||
                        (rd_data_reg.request_kind == KIND_LOW_B))
                     : (rd_data_reg.request_kind == KIND_HIGH);
    assign walk_done = (walk_left_reg == '0) && !pend_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = drop_op ? ST_DROP : ST_READ;
            end
            ST_DROP:
            begin
                if (walk_done)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        op_next         = op_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        popped_next     = popped_reg;
        pop_addr_next   = pop_addr_reg;
        low_pair_next   = low_pair_reg;
        walk_rd_next    = walk_rd_reg;
        walk_wr_next    = walk_wr_reg;
        walk_left_next  = walk_left_reg;
        keep_next       = keep_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_entry_next  = out_entry_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_reg;
        mem_wdata       = item_reg;
        mem_raddr       = popped_reg ? pop_addr_reg : head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next                  = req.opcode;
                    item_next.sector_number  = req.sector_number;
                    item_next.sector_count   = req.sector_count;
                    item_next.buffer_address = req.buffer_address;
                    item_next.request_kind   = req.request_kind;
                    item_next.due_frame      = req.due_frame;
                end
            end
            ST_EXEC:
            begin
                status_next = STATUS_OK;
                popped_next = 1'b0;
                unique case (op_reg)
                    OP_PUSH_TAIL:
                    begin
                        if (full)
                            status_next = STATUS_FULL;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = tail_reg;
                            tail_next = wrap_next(tail_reg);
                            occ_next  = occ_reg + 1'b1;
                        end
                    end
                    OP_PUSH_HEAD:
                    begin
                        if (full)
                            status_next = STATUS_FULL;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = wrap_prev(head_reg);
                            head_next = wrap_prev(head_reg);
                            occ_next  = occ_reg + 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (empty)
                            status_next = STATUS_EMPTY;
                        else
                        begin
                            popped_next   = 1'b1;
                            pop_addr_next = head_reg;
                            head_next     = wrap_next(head_reg);
                            occ_next      = occ_reg - 1'b1;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (empty)
                            status_next = STATUS_EMPTY;
                    end
                    OP_DROP_LOW, OP_DROP_KIND3:
                    begin
                        low_pair_next  = (op_reg == OP_DROP_LOW);
                        walk_rd_next   = head_reg;
                        walk_wr_next   = tail_reg;
                        walk_left_next = occ_reg;
                        keep_next      = '0;
                        pend_next      = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DROP:
            begin
                // survivors are rewritten behind the old tail, never over an unread slot
                mem_raddr = walk_rd_reg;
                pend_next = (walk_left_reg != '0);
                if (walk_left_reg != '0)
                begin
                    walk_rd_next   = wrap_next(walk_rd_reg);
                    walk_left_next = walk_left_reg - 1'b1;
                end
                if (pend_reg && !drop_hit)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = walk_wr_reg;
                    mem_wdata    = rd_data_reg;
                    walk_wr_next = wrap_next(walk_wr_reg);
                    keep_next    = keep_reg + 1'b1;
                end
                if (walk_done)
                begin
                    head_next = tail_reg;
                    tail_next = walk_wr_reg;
                    occ_next  = keep_reg;
                end
            end
            ST_READ:
            begin
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = COUNT_W'(occ_reg);
                    out_entry_next  = (!popped_reg && empty) ? '0 : rd_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            popped_reg    <= 1'b0;
            walk_left_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            popped_reg    <= popped_next;
            walk_left_reg <= walk_left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        item_reg       <= item_next;
        status_reg     <= status_next;
        pop_addr_reg   <= pop_addr_next;
        low_pair_reg   <= low_pair_next;
        walk_rd_reg    <= walk_rd_next;
        walk_wr_reg    <= walk_wr_next;
        keep_reg       <= keep_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_entry_reg  <= out_entry_next;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign req.ready              = (state_reg == ST_IDLE);
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.entry_count        = out_count_reg;
    assign rsp.out_sector_number  = out_entry_reg.sector_number;
    assign rsp.out_sector_count   = out_entry_reg.sector_count;
    assign rsp.out_buffer_address = out_entry_reg.buffer_address;
    assign rsp.out_request_kind   = out_entry_reg.request_kind;
    assign rsp.out_due_frame      = out_entry_reg.due_frame;

endmodule

/* verif/tb_request_deque_with_kind_filter_core.sv */
// self-checking testbench for the request deque with kind filter core
module tb_request_deque_with_kind_filter_core;

    timeunit 1ns;
    timeprecision 1ps;

    import rdqkf_pkg::*;

    localparam int QUEUE_DEPTH    = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int END_TAIL       = 60;
    localparam int PHASE_WORDS    = 330;
    localparam int BLOCK_WORDS    = 30;

    localparam logic [OP_W-1:0] OP_NOP_A = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP_B = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        entry_t          body;
    } request_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        entry_t              body;
    } deque_result_t;

    typedef struct packed {
        request_word_t word;
        logic          typed;
        deque_result_t typed_result;
    } stimulus_t;

    logic clk = 1'b0;
    logic rst_n;

    rdqkf_req_if req_bus ();
    rdqkf_rsp_if rsp_bus ();

    request_deque_with_kind_filter_core #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    stimulus_t     pending_words[$];
    deque_result_t expected_results[$];
    stimulus_t     in_flight;
    stimulus_t     next_stim;

    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    logic rsp_hold;
    int   fail_count;
    int   stall_cycles;

    // shadow deque
    entry_t slot_mem[QUEUE_DEPTH];
    int     head_slot;
    int     tail_slot;
    int     held;

    int op_tally[8];
    int full_rejects;
    int empty_rejects;
    int deepest_fill;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int next_slot(int p);
        return (p + 1) % QUEUE_DEPTH;
    endfunction

    function automatic int prev_slot(int p);
        return (p + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
    endfunction

    function automatic entry_t mk_entry(logic [31:0] sn, logic [31:0] sc, logic [31:0] ba,
                                        logic [3:0] kd, logic [31:0] df);
        entry_t e;
        e.sector_number  = sn;
        e.sector_count   = sc;
        e.buffer_address = ba;
        e.request_kind   = kd;
        e.due_frame      = df;
        return e;
    endfunction

    task automatic predict_deque(input request_word_t w, output deque_result_t r);
        entry_t survivors[QUEUE_DEPTH];
        int     n;
        int     i;
        bit     popped;
        bit     drop_it;
        r.status = STATUS_OK;
        r.body   = '0;
        popped   = 1'b0;
        case (w.opcode)
            OP_PUSH_TAIL:
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    slot_mem[tail_slot] = w.body;
                    tail_slot = next_slot(tail_slot);
                    held++;
                end
            end
            OP_PUSH_HEAD:
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    head_slot = prev_slot(head_slot);
                    slot_mem[head_slot] = w.body;
                    held++;
                end
            end
            OP_POP:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.body    = slot_mem[head_slot];
                    popped    = 1'b1;
                    head_slot = next_slot(head_slot);
                    held--;
                end
            end
            OP_PEEK:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
            end
            OP_DROP_LOW, OP_DROP_KIND3:
            begin
                n = held;
                for (i = 0; i < n; i++)
                begin
                    survivors[i] = slot_mem[(head_slot + i) % QUEUE_DEPTH];
                end
                // survivors are rewritten from the old tail onward
                head_slot = tail_slot;
                held = 0;
                for (i = 0; i < n; i++)
                begin
                    if (w.opcode == OP_DROP_LOW)
                    begin
                        drop_it = survivors[i].request_kind == KIND_LOW_A ||
                                  survivors[i].request_kind == KIND_LOW_B;
                    end
                    else
                    begin
                        drop_it = survivors[i].request_kind == KIND_HIGH;
                    end
                    if (!drop_it)
                    begin
                        slot_mem[tail_slot] = survivors[i];
                        tail_slot = next_slot(tail_slot);
                        held++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(held);
        if (!popped)
        begin
            r.body = (held == 0) ? entry_t'('0) : slot_mem[head_slot];
        end
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input entry_t body, input int typed,
                           input logic [STATUS_W-1:0] st, input int cnt, input entry_t exp_body);
        stimulus_t s;
        s.word.opcode              = op;
        s.word.body                = body;
        s.typed                    = (typed != 0);
        s.typed_result.status      = st;
        s.typed_result.count       = COUNT_W'(cnt);
        s.typed_result.body        = exp_body;
        pending_words.push_back(s);
    endtask

    function automatic request_word_t random_word(int push_pct);
        request_word_t w;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            w.opcode = ($urandom_range(1) == 0) ? OP_NOP_A : OP_NOP_B;
        end
        else if (pick < 3 + push_pct)
        begin
            w.opcode = ($urandom_range(3) == 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                w.opcode = OP_POP;
            else if (pick < 70)
                w.opcode = OP_PEEK;
            else if (pick < 85)
                w.opcode = OP_DROP_LOW;
            else
                w.opcode = OP_DROP_KIND3;
        end
        w.body = mk_entry($urandom, $urandom, $urandom,
                          ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(3)),
                          $urandom);
        return w;
    endfunction

    task automatic queue_random(input request_word_t w);
        stimulus_t s;
        s.word         = w;
        s.typed        = 1'b0;
        s.typed_result = '0;
        pending_words.push_back(s);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_words.size() != 0 || req_bus.valid || expected_results.size() != 0 ||
               rsp_hold || hold_req)
        begin
            @(posedge clk);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else if (!req_bus.valid || req_bus.ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_stim = pending_words.pop_front();
                in_flight              <= next_stim;
                req_bus.valid          <= 1'b1;
                req_bus.opcode         <= next_stim.word.opcode;
                req_bus.sector_number  <= next_stim.word.body.sector_number;
                req_bus.sector_count   <= next_stim.word.body.sector_count;
                req_bus.buffer_address <= next_stim.word.body.buffer_address;
                req_bus.request_kind   <= next_stim.word.body.request_kind;
                req_bus.due_frame      <= next_stim.word.body.due_frame;
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // response ready
    always @(posedge clk)
    begin
        if (!rst_n || rsp_hold)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= $urandom_range(99) >= recv_stall_pct;
    end

    // long receiver hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold <= 1'b0;
                hold_req <= 1'b0;
            end
        end
    end

    // prediction and checking
    always @(posedge clk)
    begin
        deque_result_t predicted;
        deque_result_t want;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                predict_deque(in_flight.word, predicted);
                expected_results.push_back(in_flight.typed ? in_flight.typed_result : predicted);
                op_tally[in_flight.word.opcode]++;
                if (predicted.status == STATUS_FULL)
                    full_rejects++;
                if (predicted.status == STATUS_EMPTY)
                    empty_rejects++;
                if (held > deepest_fill)
                    deepest_fill = held;
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("response word with no expected result");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_bus.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, rsp_bus.status);
                        fail_count++;
                    end
                    if (rsp_bus.entry_count !== want.count)
                    begin
                        $error("entry_count expected %0d got %0d", want.count,
                               rsp_bus.entry_count);
                        fail_count++;
                    end
                    if (rsp_bus.out_sector_number !== want.body.sector_number)
                    begin
                        $error("out_sector_number expected %h got %h",
                               want.body.sector_number, rsp_bus.out_sector_number);
                        fail_count++;
                    end
                    if (rsp_bus.out_sector_count !== want.body.sector_count)
                    begin
                        $error("out_sector_count expected %h got %h",
                               want.body.sector_count, rsp_bus.out_sector_count);
                        fail_count++;
                    end
                    if (rsp_bus.out_buffer_address !== want.body.buffer_address)
                    begin
                        $error("out_buffer_address expected %h got %h",
                               want.body.buffer_address, rsp_bus.out_buffer_address);
                        fail_count++;
                    end
                    if (rsp_bus.out_request_kind !== want.body.request_kind)
                    begin
                        $error("out_request_kind expected %0d got %0d",
                               want.body.request_kind, rsp_bus.out_request_kind);
                        fail_count++;
                    end
                    if (rsp_bus.out_due_frame !== want.body.due_frame)
                    begin
                        $error("out_due_frame expected %h got %h",
                               want.body.due_frame, rsp_bus.out_due_frame);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        entry_t zero_entry;
        entry_t ones_entry;
        int     send_pcts[4];
        int     recv_pcts[4];
        int     biases[3];
        int     phase;
        int     k;

        zero_entry = '0;
        ones_entry = '1;
        send_pcts = '{0, 52, 0, 23};
        recv_pcts = '{0, 0, 52, 23};
        biases    = '{80, 60, 20};

        rst_n                  = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.opcode         = '0;
        req_bus.sector_number  = '0;
        req_bus.sector_count   = '0;
        req_bus.buffer_address = '0;
        req_bus.request_kind   = '0;
        req_bus.due_frame      = '0;
        rsp_bus.ready          = 1'b0;
        in_flight              = '0;
        hold_req               = 1'b0;
        rsp_hold               = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        fail_count             = 0;
        stall_cycles           = 0;
        head_slot              = 0;
        tail_slot              = 0;
        held                   = 0;
        full_rejects           = 0;
        empty_rejects          = 0;
        deepest_fill           = 0;
        foreach (op_tally[i])
            op_tally[i] = 0;
        foreach (slot_mem[i])
            slot_mem[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words
        add_row(OP_PEEK,       zero_entry, 1, STATUS_EMPTY, 0, zero_entry);
        add_row(OP_POP,        zero_entry, 1, STATUS_EMPTY, 0, zero_entry);
        add_row(OP_DROP_LOW,   zero_entry, 1, STATUS_OK,    0, zero_entry);
        add_row(OP_DROP_KIND3, zero_entry, 1, STATUS_OK,    0, zero_entry);
        add_row(OP_NOP_A,      zero_entry, 1, STATUS_OK,    0, zero_entry);
        add_row(OP_PUSH_TAIL,  ones_entry, 1, STATUS_OK,    1, ones_entry);
        add_row(OP_PUSH_HEAD,  zero_entry, 1, STATUS_OK,    2, zero_entry);
        add_row(OP_NOP_B,      zero_entry, 1, STATUS_OK,    2, zero_entry);
        add_row(OP_PUSH_TAIL, mk_entry($urandom, $urandom, $urandom, KIND_LOW_A, $urandom),
                0, STATUS_OK, 0, zero_entry);
        add_row(OP_PUSH_TAIL, mk_entry($urandom, $urandom, $urandom, KIND_LOW_B, $urandom),
                0, STATUS_OK, 0, zero_entry);
        add_row(OP_PUSH_TAIL, mk_entry($urandom, $urandom, $urandom, KIND_HIGH, $urandom),
                0, STATUS_OK, 0, zero_entry);
        add_row(OP_PUSH_HEAD, mk_entry($urandom, $urandom, $urandom, KIND_HIGH, $urandom),
                0, STATUS_OK, 0, zero_entry);
        add_row(OP_PEEK,       zero_entry, 0, STATUS_OK, 0, zero_entry);
        add_row(OP_DROP_KIND3, zero_entry, 0, STATUS_OK, 0, zero_entry);
        add_row(OP_DROP_LOW,   zero_entry, 0, STATUS_OK, 0, zero_entry);
        add_row(OP_PUSH_TAIL, mk_entry($urandom, $urandom, $urandom, 4'd4, $urandom),
                0, STATUS_OK, 0, zero_entry);
        add_row(OP_POP,        zero_entry, 0, STATUS_OK,    0, zero_entry);
        add_row(OP_POP,        zero_entry, 1, STATUS_OK,    1, ones_entry);
        add_row(OP_POP,        zero_entry, 0, STATUS_OK,    0, zero_entry);
        add_row(OP_POP,        zero_entry, 1, STATUS_EMPTY, 0, zero_entry);
        add_row(OP_PUSH_HEAD, mk_entry($urandom, $urandom, $urandom, 4'd0, $urandom),
                0, STATUS_OK, 0, zero_entry);
        add_row(OP_DROP_LOW,   zero_entry, 0, STATUS_OK, 0, zero_entry);
        add_row(OP_POP,        zero_entry, 0, STATUS_OK, 0, zero_entry);
        wait_drained();

        // long receiver hold-off, which stalls the sequencer, then fill to full
        hold_req <= 1'b1;
        for (k = 0; k < 44; k++)
        begin
            queue_random(random_word(100));
        end
        for (k = 0; k < 6; k++)
        begin
            queue_random(random_word(0));
        end
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                queue_random(random_word(biases[(k / BLOCK_WORDS) % 3]));
            end
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (END_TAIL) @(posedge clk);

        $display("words: %0d push tail, %0d push head, %0d pop, %0d peek, %0d drop, %0d no-op",
                 op_tally[OP_PUSH_TAIL], op_tally[OP_PUSH_HEAD], op_tally[OP_POP],
                 op_tally[OP_PEEK], op_tally[OP_DROP_LOW] + op_tally[OP_DROP_KIND3],
                 op_tally[OP_NOP_A] + op_tally[OP_NOP_B]);
        $display("rejected %0d full and %0d empty, deepest fill %0d entries",
                 full_rejects, empty_rejects, deepest_fill);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
